// File: rtl/m2pm_pkg.sv
// Package for the 2x2 matrix power modulo unit.
// Widths shared by the datapath and sequencer, plus the state codes and control struct of the sequencer.
package m2pm_pkg;

   localparam int unsigned EXP_WIDTH   = 31;
   localparam int unsigned ENTRY_WIDTH = 31;
   localparam int unsigned MOD_WIDTH   = 16;
   localparam int unsigned RES_WIDTH   = 16;
   localparam int unsigned CNT_WIDTH   = 6;
   localparam logic [MOD_WIDTH-1:0] MOD_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

   // Requests from the sequencer to the modular product unit
   typedef struct packed {
      logic start_reduce;
      logic start_square;
      logic start_mult;
   } ctrl_type;

endpackage

// File: rtl/matrix2x2_power_mod_unit.sv
// Top level of the 2x2 matrix power modulo unit: handshakes, modulus register, result register.
// Depends on m2pm_pkg, m2pm_seq and m2pm_modmul.
//
// Raises a 2x2 matrix to a power of at least one, every entry modulo the csr_ modulus
// (0 acts as 65536). One shared bit-serial multiply-accumulate runs each step over all
// 31 operand bits; the entries are reduced in 4 steps, an exponent scan follows, and each
// matrix square or multiply costs 8 steps. One item is worked on at a time; the next item
// is taken only once the previous result has left the output register.
module matrix2x2_power_mod_unit
   import m2pm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // exponent[30:0], entry_r0c0[61:31], r0c1[92:62], r1c0[123:93], r1c1[154:124], zero pad
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_r0c0[15:0], r0c1[31:16], r1c0[47:32], r1c1[63:48]
   output logic [63:0]  rsp_tdata
);

   logic [MOD_WIDTH-1:0]   mod_ff;
   logic [MOD_WIDTH:0]     mod_eff;
   logic                   busy, done, start;
   logic [4*RES_WIDTH-1:0] result;
   logic [4*RES_WIDTH-1:0] out_ff;
   logic                   out_valid_ff;

   // Modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_RESET;
      end else if (csr_valid && csr_ready) begin
         mod_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;
   assign mod_eff   = (mod_ff == '0) ? {1'b1, 16'h0000} : {1'b0, mod_ff};

   // Take a new item only when idle and the output register is empty
   assign req_tready = !busy && !out_valid_ff;
   assign start      = req_tvalid && req_tready;

   m2pm_seq u_seq (
      .clock (clock), .reset (reset), .start (start), .mod (mod_eff),
      .exponent (req_tdata[EXP_WIDTH-1:0]),
      .entries (req_tdata[EXP_WIDTH +: 4*ENTRY_WIDTH]),
      .busy (busy), .done (done), .result (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (done) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (done) begin
         out_ff <= result;
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("item taken while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy)) else $error("done without a job");
   a_out_set: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result lost");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_tvalid) else $error("result overwritten");

endmodule

// File: rtl/m2pm_modmul.sv
// Bit-serial modular multiply-accumulate: (a*b + c) mod m, one bit of b per cycle.
// Depends on m2pm_pkg. Operands a and c must already be below m.
module m2pm_modmul
   import m2pm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_WIDTH:0]   mod,
   input  logic [MOD_WIDTH-1:0] a,
   input  logic [ENTRY_WIDTH-1:0] b,
   input  logic [MOD_WIDTH-1:0] c,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] result
);

   logic [ENTRY_WIDTH-1:0] b_ff, b_in;
   logic [MOD_WIDTH:0]     acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]   c_ff, c_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MOD_WIDTH+1:0]   dbl, dbl_r, add, add_r, fin, fin_r;

   // Horner step: acc = 2*acc + bit*a, the doubling and the addition each reduced by one
   // conditional subtract; c is added and reduced on the last step
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, mod}) ? dbl - {1'b0, mod} : dbl;
      add   = dbl_r + (b_ff[ENTRY_WIDTH-1] ? {2'b00, a} : '0);
      add_r = (add >= {1'b0, mod}) ? add - {1'b0, mod} : add;
      fin   = {1'b0, add_r[MOD_WIDTH:0]} + {2'b00, c_ff};
      fin_r = (fin >= {1'b0, mod}) ? fin - {1'b0, mod} : fin;
      b_in    = b_ff;
      acc_in  = acc_ff;
      c_in    = c_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         b_in    = b;
         acc_in  = '0;
         c_in    = c;
         cnt_in  = CNT_WIDTH'(ENTRY_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = add_r[MOD_WIDTH:0];
         b_in   = {b_ff[ENTRY_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            acc_in  = fin_r[MOD_WIDTH:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      b_ff   <= b_in;
      acc_ff <= acc_in;
      c_ff   <= c_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[MOD_WIDTH-1:0];

endmodule

// File: rtl/m2pm_seq.sv
// Sequencer: reduces the entries, scans the exponent and issues matrix products.
// Depends on m2pm_pkg and m2pm_modmul; one modmul serves all entries in turn.
module m2pm_seq
   import m2pm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MOD_WIDTH:0]     mod,
   input  logic [EXP_WIDTH-1:0]   exponent,
   input  logic [4*ENTRY_WIDTH-1:0] entries,
   output logic                   busy,
   output logic                   done,
   output logic [4*RES_WIDTH-1:0] result
);

   state_type state_ff, state_in;
   logic [EXP_WIDTH-1:0]   exp_ff, exp_in;
   logic [CNT_WIDTH-1:0]   bits_ff, bits_in;
   logic [ENTRY_WIDTH-1:0] raw_ff [4];
   logic [MOD_WIDTH-1:0]   base_ff [4];
   logic [MOD_WIDTH-1:0]   acc_ff [4];
   logic [MOD_WIDTH-1:0]   nxt_ff [4];
   // step: bit0 = which term of the dot product, bits 2:1 = result entry
   logic [2:0]             step_ff, step_in;
   logic                   issue_ff, issue_in;
   logic                   mm_start, mm_done;
   logic [MOD_WIDTH-1:0]   mm_a, mm_c, mm_res, part_ff;
   logic [ENTRY_WIDTH-1:0] mm_b;
   logic [1:0]             row, col, xi, yi;
   ctrl_type               ctrl;

   m2pm_modmul u_mm (
      .clock (clock), .reset (reset), .start (mm_start), .mod (mod),
      .a (mm_a), .b (mm_b), .c (mm_c), .done (mm_done), .result (mm_res)
   );

   // Operand selection: entry (row,col) = x[row,0]*y[0,col] + x[row,1]*y[1,col]
   always_comb begin
      row  = {1'b0, step_ff[2]};
      col  = {1'b0, step_ff[1]};
      xi   = {row[0], step_ff[0]};
      yi   = {step_ff[0], col[0]};
      mm_c = step_ff[0] ? part_ff : '0;
      mm_a = acc_ff[xi];
      mm_b = '0;
      ctrl = '0;
      case (state_ff)
         ST_REDUCE: begin
            ctrl.start_reduce = issue_ff;
            mm_a = 16'd1;
            mm_c = '0;
            mm_b = raw_ff[step_ff[1:0]];
         end
         ST_SQUARE: begin
            ctrl.start_square = issue_ff;
            mm_b = ENTRY_WIDTH'(acc_ff[yi]);
         end
         ST_MULT: begin
            ctrl.start_mult = issue_ff;
            mm_b = ENTRY_WIDTH'(base_ff[yi]);
         end
         default: ;
      endcase
      mm_start = ctrl.start_reduce | ctrl.start_square | ctrl.start_mult;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      exp_in   = exp_ff;
      bits_in  = bits_ff;
      step_in  = step_ff;
      issue_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_REDUCE;
               exp_in   = exponent;
               bits_in  = CNT_WIDTH'(EXP_WIDTH);
               step_in  = '0;
               issue_in = 1'b1;
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               if (step_ff == 3'd3) begin
                  state_in = ST_SCAN;
               end else begin
                  step_in  = step_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // drop bits up to and including the leading one
            exp_in  = {exp_ff[EXP_WIDTH-2:0], 1'b0};
            bits_in = bits_ff - 1'b1;
            if (exp_ff[EXP_WIDTH-1] || bits_ff == CNT_WIDTH'(1)) begin
               if (bits_ff == CNT_WIDTH'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQUARE;
                  step_in  = '0;
                  issue_in = 1'b1;
               end
            end
         end
         ST_SQUARE, ST_MULT: begin
            if (mm_done) begin
               if (step_ff == 3'd7) begin
                  step_in = '0;
                  if (state_ff == ST_SQUARE && exp_ff[EXP_WIDTH-1]) begin
                     state_in = ST_MULT;
                     issue_in = 1'b1;
                  end else if (bits_ff == CNT_WIDTH'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     exp_in   = {exp_ff[EXP_WIDTH-2:0], 1'b0};
                     bits_in  = bits_ff - 1'b1;
                     state_in = ST_SQUARE;
                     issue_in = 1'b1;
                  end
               end else begin
                  step_in  = step_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
      end
      exp_ff  <= exp_in;
      bits_ff <= bits_in;
      step_ff <= step_in;
   end

   // Matrix registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         for (int i = 0; i < 4; i++) begin
            raw_ff[i] <= entries[i*ENTRY_WIDTH +: ENTRY_WIDTH];
         end
      end
      if (mm_done) begin
         case (state_ff)
            ST_REDUCE: begin
               base_ff[step_ff[1:0]] <= mm_res;
               acc_ff[step_ff[1:0]]  <= mm_res;
            end
            ST_SQUARE, ST_MULT: begin
               if (!step_ff[0]) begin
                  part_ff <= mm_res;
               end else begin
                  nxt_ff[step_ff[2:1]] <= mm_res;
                  if (step_ff == 3'd7) begin
                     acc_ff[0] <= nxt_ff[0];
                     acc_ff[1] <= nxt_ff[1];
                     acc_ff[2] <= nxt_ff[2];
                     acc_ff[3] <= mm_res;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign done   = (state_ff == ST_DONE);
   assign result = {acc_ff[3], acc_ff[2], acc_ff[1], acc_ff[0]};

endmodule

// File: tb/matrix2x2_power_mod_unit_tb.sv
// Testbench for matrix2x2_power_mod_unit: random and directed matrix power jobs
// checked against a behavioural predictor held in a small scoreboard class.
// Depends on m2pm_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module matrix2x2_power_mod_unit_tb
   import m2pm_pkg::*;
();

   typedef struct packed {
      logic [15:0] r1c1;
      logic [15:0] r1c0;
      logic [15:0] r0c1;
      logic [15:0] r0c0;
   } power_result_type;

   // Scoreboard: predicts the power matrix and checks results in order
   class power_scoreboard;
      power_result_type pending_q[$];
      logic [15:0] modulus_reg;
      int errors;

      function new();
         modulus_reg = MOD_RESET;
         errors = 0;
      endfunction

      function void note_job(logic [159:0] item);
         logic [63:0] m;
         logic [63:0] b[4];
         logic [63:0] a[4];
         logic [63:0] t[4];
         logic [30:0] n;
         int top;
         int i;
         power_result_type res;
         m = (modulus_reg == 0) ? 64'd65536 : {48'd0, modulus_reg};
         n = item[30:0];
         for (i = 0; i < 4; i++) b[i] = {33'd0, item[31*(i+1) +: 31]} % m;
         top = 30;
         while (top > 0 && !n[top]) top--;
         a = b;
         for (i = top - 1; i >= 0; i--) begin
            t[0] = (a[0]*a[0] + a[1]*a[2]) % m;
            t[1] = (a[0]*a[1] + a[1]*a[3]) % m;
            t[2] = (a[2]*a[0] + a[3]*a[2]) % m;
            t[3] = (a[2]*a[1] + a[3]*a[3]) % m;
            a = t;
            if (n[i]) begin
               t[0] = (a[0]*b[0] + a[1]*b[2]) % m;
               t[1] = (a[0]*b[1] + a[1]*b[3]) % m;
               t[2] = (a[2]*b[0] + a[3]*b[2]) % m;
               t[3] = (a[2]*b[1] + a[3]*b[3]) % m;
               a = t;
            end
         end
         res.r0c0 = a[0][15:0];
         res.r0c1 = a[1][15:0];
         res.r1c0 = a[2][15:0];
         res.r1c1 = a[3][15:0];
         pending_q.push_back(res);
      endfunction

      function void check_result(logic [63:0] data);
         power_result_type exp_res;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, data);
            errors++;
         end else begin
            exp_res = pending_q.pop_front();
            if (exp_res != data) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_res, data);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   power_scoreboard sb = new();
   int idle_cycles = 0;
   bit long_hold = 1'b0;
   bit sink_on = 1'b0;

   localparam int WATCHDOG_LIMIT = 200000;

   always #10 clock = ~clock;

   matrix2x2_power_mod_unit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Result side: check accepted items, random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   initial begin : sink
      int gap;
      int k;
      @(posedge clock);
      while (!sink_on) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < 60000; k++) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("matrix2x2_power_mod_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic write_modulus(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.modulus_reg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_job(input logic [30:0] n, input logic [30:0] e0, input logic [30:0] e1,
                           input logic [30:0] e2, input logic [30:0] e3, input bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, e3, e2, e1, e0, n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_job(req_tdata);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly short exponents; a few full-width ones
   function automatic logic [30:0] rand_exp();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 31'($urandom | 32'h4000_0000);
      if (r < 4) return 31'($urandom_range(1, 31'h7FFF_FFFF));
      return 31'($urandom_range(1, 64));
   endfunction

   function automatic logic [30:0] rand_entry();
      case ($urandom_range(0, 4))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 20));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic random_jobs(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_job(rand_exp(), rand_entry(), rand_entry(), rand_entry(), rand_entry(), 1'b1);
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sink_on = 1'b1;
      @(posedge clock);

      // Directed: reset modulus, extremes of exponent and entries
      send_job(31'd1, 31'd0, 31'd1, 31'd2, 31'd3, 1'b0);
      send_job(31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      send_job(31'h7FFF_FFFF, 31'd1, 31'd1, 31'd1, 31'd0, 1'b0);
      send_job(31'd2, 31'h5555_5555, 31'h2AAA_AAAA, 31'd65535, 31'd65536, 1'b0);
      send_job(31'h4000_0000, 31'd2, 31'd0, 31'd0, 31'd2, 1'b0);
      send_job(31'd10, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0);
      drain();

      // Modulus zero acts as 65536
      write_modulus(16'd0);
      send_job(31'd5, 31'h7FFF_FFFF, 31'd65535, 31'd3, 31'h1234_5678, 1'b0);
      send_job(31'h7FFF_FFFF, 31'd3, 31'd7, 31'd11, 31'd13, 1'b0);
      drain();

      // Modulus one gives all zero
      write_modulus(16'd1);
      send_job(31'd1, 31'd5, 31'd6, 31'd7, 31'd8, 1'b0);
      send_job(31'd3, 31'h7FFF_FFFF, 31'd1, 31'd1, 31'd1, 1'b0);
      drain();

      // Largest modulus, then small prime
      write_modulus(16'hFFFF);
      send_job(31'd9, 31'd65534, 31'd65535, 31'd65536, 31'd1, 1'b0);
      drain();
      write_modulus(16'd7);
      send_job(31'd6, 31'd1, 31'd1, 31'd1, 31'd0, 1'b0);
      drain();

      // Long hold-off on the result side while jobs keep coming
      write_modulus(16'd1000);
      long_hold = 1'b1;
      random_jobs(4);
      drain();

      // Random phases over several modulus settings
      for (i = 0; i < 6; i++) begin
         case (i)
            0: write_modulus(16'd2);
            1: write_modulus(16'hFFFE);
            2: write_modulus(16'd0);
            default: write_modulus(16'($urandom_range(0, 65535)));
         endcase
         random_jobs(48);
         drain();
      end

      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("matrix2x2_power_mod_unit_tb OK");
      else
         $display("matrix2x2_power_mod_unit_tb NOT OK");
      $finish;
   end

endmodule
